FILE: rtl/rcia_pkg.sv
// ----------------------------------------------------------------------------
// rcia_pkg
// Shared types and constants for the reference-counted ID allocator: request
// codes, controller states and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package rcia_pkg;

  localparam int ID_W     = 10;
  localparam int KIND_W   = 2;
  localparam int TDATA_W  = 16;
  localparam int FLAG_W   = 3;
  localparam int FLAG_FREE = 0;
  localparam int FLAG_EXH  = 1;
  localparam int FLAG_SAT  = 2;

  typedef enum logic [KIND_W-1:0] {
    REQ_NEW = 2'd0,
    REQ_REG = 2'd1,
    REQ_REL = 2'd2,
    REQ_NOP = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic bypass;
    logic rd_en;
    logic step;
    logic eval;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic needs_read;
    logic is_new;
    logic hit;
    logic at_top;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: rtl/rcia_ram.sv
// ----------------------------------------------------------------------------
// rcia_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rcia_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rcia_ctrl.sv
// ----------------------------------------------------------------------------
// rcia_ctrl
// Controller for the ID allocator: sequences the clearing pass, item
// acceptance, count reads, the upward scan and delivery of the result.
// ----------------------------------------------------------------------------
module rcia_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  rcia_pkg::ctrl_sts_t sts,
  output rcia_pkg::ctrl_cmd_t cmd
);

  import rcia_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = sts.needs_read ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.is_new && !sts.hit && !sts.at_top) state_nxt = ST_READ;
        else state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        cmd.accept = in_fire;
        cmd.bypass = in_fire && !sts.needs_read;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_EVAL: begin
        if (sts.is_new && !sts.hit && !sts.at_top) cmd.step = 1'b1;
        else cmd.eval = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/rcia_dpath.sv
// ----------------------------------------------------------------------------
// rcia_dpath
// Datapath for the ID allocator: use-count memory, search pointer, scan
// address, item and result registers, and the output register.
// ----------------------------------------------------------------------------
module rcia_dpath #(
  parameter int NUM_IDS     = 1024,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rcia_pkg::ctrl_cmd_t          cmd,
  output rcia_pkg::ctrl_sts_t          sts,
  input  rcia_pkg::req_t               in_kind,
  input  logic [rcia_pkg::ID_W-1:0]    in_id,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rcia_pkg::ID_W-1:0]    out_id,
  output logic [rcia_pkg::FLAG_W-1:0]  out_flags
);

  import rcia_pkg::*;

  localparam int IDW = $clog2(NUM_IDS);
  localparam int CW  = COUNT_WIDTH;
  localparam logic [IDW-1:0] TOP_ID  = IDW'(NUM_IDS - 1);
  localparam logic [CW-1:0]  CNT_MAX = {CW{1'b1}};
  localparam logic [CW-1:0]  CNT_ONE = CW'(1);

  logic [IDW-1:0]    ptr_r, ptr_nxt;
  logic [IDW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic              reuse_r, reuse_nxt;
  logic              out_valid_r, out_valid_nxt;
  req_t              kind_r, kind_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [IDW-1:0]    addr_r, addr_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic              res_free_r, res_free_nxt;
  logic              res_exh_r, res_exh_nxt;
  logic              res_sat_r, res_sat_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [FLAG_W-1:0] out_flags_r, out_flags_nxt;

  logic              in_range;
  logic [IDW-1:0]    in_idx;
  logic [IDW-1:0]    id_idx;
  logic              we;
  logic [IDW-1:0]    waddr;
  logic [CW-1:0]     wdata;
  logic [CW-1:0]     rd_data;
  logic              rd_zero;
  logic              rd_one;
  logic              rd_max;
  logic              freed;

  assign in_range = (32'(in_id) < 32'(NUM_IDS));
  assign in_idx   = IDW'(in_id);
  assign id_idx   = IDW'(id_r);
  assign rd_zero  = (rd_data == '0);
  assign rd_one   = (rd_data == CNT_ONE);
  assign rd_max   = (rd_data == CNT_MAX);
  assign freed    = rd_zero || rd_one;

  rcia_ram #(
    .WIDTH(CW),
    .DEPTH(NUM_IDS)
  ) u_counts (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(addr_r),
    .rdata(rd_data)
  );

  always_comb begin
    sts.clr_last   = (clr_cnt_r == TOP_ID);
    sts.needs_read = (in_kind == REQ_NEW) ||
                     (((in_kind == REQ_REG) || (in_kind == REQ_REL)) && in_range);
    sts.is_new     = (kind_r == REQ_NEW);
    sts.hit        = rd_zero;
    sts.at_top     = (addr_r == TOP_ID);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = '0;
    if (cmd.clr_en) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
    end else if (cmd.eval) begin
      case (kind_r)
        REQ_NEW: begin
          we    = rd_zero;
          wdata = CNT_ONE;
        end
        REQ_REG: begin
          we    = !rd_max;
          wdata = CW'(rd_data + CNT_ONE);
        end
        REQ_REL: begin
          we    = !rd_zero;
          wdata = CW'(rd_data - CNT_ONE);
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_comb begin
    ptr_nxt       = ptr_r;
    clr_cnt_nxt   = clr_cnt_r;
    reuse_nxt     = reuse_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    addr_nxt      = addr_r;
    res_id_nxt    = res_id_r;
    res_free_nxt  = res_free_r;
    res_exh_nxt   = res_exh_r;
    res_sat_nxt   = res_sat_r;
    out_id_nxt    = out_id_r;
    out_flags_nxt = out_flags_r;

    if (cmd.clr_en) clr_cnt_nxt = clr_cnt_r + IDW'(1);
    if (cfg_wr_en) reuse_nxt = cfg_wr_data;

    if (cmd.accept) begin
      kind_nxt = in_kind;
      id_nxt   = in_id;
      addr_nxt = (in_kind == REQ_NEW) ? ptr_r : in_idx;
    end

    if (cmd.bypass) begin
      res_id_nxt   = in_id;
      res_free_nxt = (in_kind == REQ_REL);
      res_exh_nxt  = 1'b0;
      res_sat_nxt  = 1'b0;
    end

    if (cmd.step) addr_nxt = addr_r + IDW'(1);

    if (cmd.eval) begin
      res_id_nxt   = id_r;
      res_free_nxt = 1'b0;
      res_exh_nxt  = 1'b0;
      res_sat_nxt  = 1'b0;
      unique case (kind_r)
        REQ_NEW: begin
          if (rd_zero) begin
            res_id_nxt = ID_W'(addr_r);
            ptr_nxt    = addr_r;
          end else begin
            res_id_nxt  = '0;
            res_exh_nxt = 1'b1;
          end
        end
        REQ_REG: begin
          res_sat_nxt = rd_max;
        end
        REQ_REL: begin
          res_free_nxt = freed;
          if (freed && (id_idx < ptr_r) && reuse_r) ptr_nxt = id_idx;
        end
        default: res_id_nxt = id_r;
      endcase
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = res_id_r;
      out_flags_nxt = {res_sat_r, res_exh_r, res_free_r};
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      clr_cnt_r   <= '0;
      reuse_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      reuse_r     <= reuse_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    id_r        <= id_nxt;
    addr_r      <= addr_nxt;
    res_id_r    <= res_id_nxt;
    res_free_r  <= res_free_nxt;
    res_exh_r   <= res_exh_nxt;
    res_sat_r   <= res_sat_nxt;
    out_id_r    <= out_id_nxt;
    out_flags_r <= out_flags_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_id    = out_id_r;
  assign out_flags = out_flags_r;

endmodule

FILE: rtl/refcounted_id_allocator_core.sv
// ----------------------------------------------------------------------------
// refcounted_id_allocator_core
// Reference-counted ID allocator: hands out free IDs by an upward scan from
// a search pointer, and counts registrations and releases per ID.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   in_      slave      tdata: id_value[9:0]; tuser: req_type[1:0]
//   out_     master     tdata: result_id[9:0]; tuser: id_now_free, exhausted,
//                       count_saturated
//   cfg_     write      wr_data: allow_reuse
//
// After reset the use-count memory is cleared one entry a cycle, all NUM_IDS
// entries, while in_tready stays low.
// A register or release passes through accept, memory read, update and result.
// A new-ID request adds a memory read and an update step for each ID in use that
// the scan steps over; each probe is one registered read of the count memory.
// An unused request type or an ID beyond the space goes from accept straight to result.
// The result sits in an output register; a stalled output holds the block
// in its result step until out_tready frees the register.
// ----------------------------------------------------------------------------
module refcounted_id_allocator_core #(
  parameter int NUM_IDS     = 1024,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rcia_pkg::TDATA_W-1:0]   in_tdata,   // id_value[9:0], zero pad
  input  logic [rcia_pkg::KIND_W-1:0]    in_tuser,   // req_type[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rcia_pkg::TDATA_W-1:0]   out_tdata,  // result_id[9:0], zero pad
  output logic [rcia_pkg::FLAG_W-1:0]    out_tuser,  // id_now_free, exhausted,
                                                     // count_saturated
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data // allow_reuse
);

  import rcia_pkg::*;

  ctrl_cmd_t       cmd;
  ctrl_sts_t       sts;
  logic [ID_W-1:0] out_id;

  rcia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcia_dpath #(
    .NUM_IDS    (NUM_IDS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (req_t'(in_tuser)),
    .in_id      (in_tdata[ID_W-1:0]),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_id     (out_id),
    .out_flags  (out_tuser)
  );

  assign out_tdata = TDATA_W'(out_id);

endmodule

FILE: rtl/rcia_checker.sv
// ----------------------------------------------------------------------------
// rcia_checker
// Port-level checks for the ID allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rcia_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [rcia_pkg::TDATA_W-1:0] out_tdata,
  input logic [rcia_pkg::FLAG_W-1:0]  out_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready
);

  import rcia_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output item changed.");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tuser))
    else $error("More than one result flag set.");

  a_exh_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[FLAG_EXH] |-> (out_tdata == '0))
    else $error("Exhausted result carries a nonzero ID.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted while an item is in progress.");

endmodule

bind refcounted_id_allocator_core rcia_checker u_rcia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);
